### src/mdfl_pkg.sv
// ----------------------------------------------------------------------------
// mdfl_pkg
// Shared types, codes and the CRC-8 step for the motor drive frame link.
// ----------------------------------------------------------------------------
package mdfl_pkg;

    localparam int FRAME_LEN_DEF = 10;
    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [7:0] OPCODE_RESET = 8'd100;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [1:0] {
        FUNC_DRIVE   = 2'd0,
        FUNC_RX_BYTE = 2'd1,
        FUNC_TIMEOUT = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_ID  = 2'd2,
        ST_BAD_CRC = 2'd3
    } status_t;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx_byte;
        logic               last;
        logic [1:0]         status;
        logic signed [15:0] current;
        logic signed [15:0] velocity;
        logic [15:0]        position;
    } res_t;

    typedef struct packed {
        logic start;
        logic byte_en;
        logic timeout_en;
    } rx_ctrl_t;

    localparam res_t RES_ZERO = '{default: '0};

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc;
        d = data;
        for (int k = 0; k < 8; k++)
        begin
            if ((c[0] ^ d[0]) == 1'b1)
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

### src/mdfl_tx.sv
// ----------------------------------------------------------------------------
// mdfl_tx
// Drive frame builder: one frame byte per step, running CRC-8 on the fly.
// ----------------------------------------------------------------------------
module mdfl_tx #(
    parameter int FRAME_LEN = mdfl_pkg::FRAME_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic [7:0]         motor_id,
    input  logic [15:0]        rpm,
    input  logic [7:0]         opcode,
    output mdfl_pkg::res_t     res,
    output logic               frame_done
);
    import mdfl_pkg::*;

    localparam int TX_W = $clog2(FRAME_LEN);

    logic [TX_W-1:0] idx_reg;
    logic [TX_W-1:0] idx_next;
    logic [7:0]      crc_reg;
    logic [7:0]      crc_next;
    logic [7:0]      frame_byte;

    assign frame_done = (idx_reg == TX_W'(FRAME_LEN - 1));

    always_comb
    begin
        priority if (frame_done)
        begin
            frame_byte = crc_reg;
        end
        else if (idx_reg == TX_W'(0))
        begin
            frame_byte = motor_id;
        end
        else if (idx_reg == TX_W'(1))
        begin
            frame_byte = opcode;
        end
        else if (idx_reg == TX_W'(2))
        begin
            frame_byte = rpm[15:8];
        end
        else if (idx_reg == TX_W'(3))
        begin
            frame_byte = rpm[7:0];
        end
        else
        begin
            frame_byte = 8'h00;
        end
    end

    always_comb
    begin
        res         = RES_ZERO;
        res.kind    = KIND_TX;
        res.tx_byte = frame_byte;
        res.last    = frame_done;
    end

    always_comb
    begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        if (step_en)
        begin
            if (frame_done)
            begin
                idx_next = '0;
                crc_next = '0;
            end
            else
            begin
                idx_next = idx_reg + TX_W'(1);
                crc_next = crc_feed(crc_reg, frame_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            crc_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
        end
    end

endmodule

### src/mdfl_rx.sv
// ----------------------------------------------------------------------------
// mdfl_rx
// Reply receiver: collects reply bytes, checks id and CRC, reports status.
// ----------------------------------------------------------------------------
module mdfl_rx #(
    parameter int FRAME_LEN = mdfl_pkg::FRAME_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mdfl_pkg::rx_ctrl_t  ctrl,
    input  logic [7:0]          motor_id,
    input  logic [7:0]          rx_byte,
    output mdfl_pkg::res_t      res,
    output logic                res_valid
);
    import mdfl_pkg::*;

    localparam int CNT_W = ($clog2(FRAME_LEN) > 3) ? $clog2(FRAME_LEN) : 3;

    logic [7:0]       expected_id_reg;
    logic [7:0]       expected_id_next;
    logic             awaiting_reg;
    logic             awaiting_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic [7:0]       frame_reg [8];
    logic             frame_end;
    logic             store_en;

    assign frame_end = (count_reg == CNT_W'(FRAME_LEN - 1));
    assign store_en  = ctrl.byte_en && awaiting_reg && !frame_end
                       && ({1'b0, count_reg} < (CNT_W + 1)'(8));

    always_comb
    begin
        res       = RES_ZERO;
        res.kind  = KIND_STATUS;
        res_valid = 1'b0;
        if (ctrl.timeout_en && awaiting_reg)
        begin
            res_valid  = 1'b1;
            res.status = ST_SHORT;
        end
        else if (ctrl.byte_en && awaiting_reg && frame_end)
        begin
            res_valid = 1'b1;
            priority if (frame_reg[0] != expected_id_reg)
            begin
                res.status = ST_BAD_ID;
            end
            else if (rx_byte != crc_reg)
            begin
                res.status = ST_BAD_CRC;
            end
            else
            begin
                res.status   = ST_OK;
                res.current  = {frame_reg[2], frame_reg[3]};
                res.velocity = {frame_reg[5], frame_reg[4]};
                res.position = {frame_reg[6], frame_reg[7]};
            end
        end
    end

    always_comb
    begin
        expected_id_next = expected_id_reg;
        awaiting_next    = awaiting_reg;
        count_next       = count_reg;
        crc_next         = crc_reg;
        priority if (ctrl.start)
        begin
            expected_id_next = motor_id;
            awaiting_next    = 1'b1;
            count_next       = '0;
            crc_next         = '0;
        end
        else if (res_valid)
        begin
            awaiting_next = 1'b0;
            count_next    = '0;
            crc_next      = '0;
        end
        else if (ctrl.byte_en && awaiting_reg)
        begin
            count_next = count_reg + CNT_W'(1);
            crc_next   = crc_feed(crc_reg, rx_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= '0;
            awaiting_reg    <= 1'b0;
            count_reg       <= '0;
            crc_reg         <= '0;
        end
        else
        begin
            expected_id_reg <= expected_id_next;
            awaiting_reg    <= awaiting_next;
            count_reg       <= count_next;
            crc_reg         <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            frame_reg[count_reg[2:0]] <= rx_byte;
        end
    end

endmodule

### src/motor_drive_frame_link.sv
// Motor drive frame link. Each input transaction is held in an input register
// and handled there; results leave through an output register, so a new input
// enters an empty input register while a finished result waits downstream.
// A drive request holds the input register until the frame builder has sent
// all FRAME_LEN frame bytes (10 by default), one per cycle while the output
// register accepts, the CRC byte last with tlast set. Status results appear
// only on the last reply byte (the tenth by default) or a timeout while a
// reply is pending; other reply bytes produce no output transaction.
// ----------------------------------------------------------------------------
// motor_drive_frame_link
// Top level: stream ports, opcode register, input and output registers.
// ----------------------------------------------------------------------------
module motor_drive_frame_link #(
    parameter int FRAME_LEN = mdfl_pkg::FRAME_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [7:0]                          cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // motor_id[7:0], rpm[23:8], rx_byte[31:24]
    input  logic [mdfl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func[1:0]
    input  logic [mdfl_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tx_byte[7:0], status[9:8], current[25:10], velocity[41:26],
    // position[57:42], zero[63:58]
    output logic [mdfl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // kind[0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import mdfl_pkg::*;

    logic [7:0]  opcode_reg;
    logic        in_valid_reg;
    logic [1:0]  func_reg;
    logic [7:0]  motor_id_reg;
    logic [15:0] rpm_reg;
    logic [7:0]  rx_byte_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        out_res_reg;
    res_t        res_sel;
    res_t        tx_res;
    res_t        rx_res;
    logic        rx_res_valid;
    logic        tx_done;
    logic        out_ready;
    logic        step;
    logic        is_drive;
    logic        consume;
    rx_ctrl_t    rx_ctrl;

    assign cfg_ready     = 1'b1;
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_ready;
    assign is_drive      = (func_reg == FUNC_DRIVE);
    assign consume       = step && (!is_drive || tx_done);
    assign s_axis_tready = !in_valid_reg || consume;

    assign rx_ctrl.start      = step && is_drive && tx_done;
    assign rx_ctrl.byte_en    = step && (func_reg == FUNC_RX_BYTE);
    assign rx_ctrl.timeout_en = step && (func_reg == FUNC_TIMEOUT);

    mdfl_tx #(
        .FRAME_LEN (FRAME_LEN)
    ) u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step && is_drive),
        .motor_id   (motor_id_reg),
        .rpm        (rpm_reg),
        .opcode     (opcode_reg),
        .res        (tx_res),
        .frame_done (tx_done)
    );

    mdfl_rx #(
        .FRAME_LEN (FRAME_LEN)
    ) u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rx_ctrl),
        .motor_id  (motor_id_reg),
        .rx_byte   (rx_byte_reg),
        .res       (rx_res),
        .res_valid (rx_res_valid)
    );

    assign res_sel        = is_drive ? tx_res : rx_res;
    assign out_valid_next = step && (is_drive || rx_res_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg    <= OPCODE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                opcode_reg <= cfg_data;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= out_valid_next;
            end
        end
    end

    // hold payload and output result; load each on its transaction
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            func_reg     <= s_axis_tuser;
            motor_id_reg <= s_axis_tdata[7:0];
            rpm_reg      <= s_axis_tdata[23:8];
            rx_byte_reg  <= s_axis_tdata[31:24];
        end
        if (out_ready && out_valid_next)
        begin
            out_res_reg <= res_sel;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tdata  = {6'b0, out_res_reg.position, out_res_reg.velocity,
                            out_res_reg.current, out_res_reg.status,
                            out_res_reg.tx_byte};

endmodule

### src/mdfl_chk.sv
// ----------------------------------------------------------------------------
// mdfl_chk
// Port-level checks for the motor drive frame link, bound to the top level.
// ----------------------------------------------------------------------------
module mdfl_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [mdfl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic                                m_axis_tuser,
    input logic                                m_axis_tlast
);
    import mdfl_pkg::*;

    // frame end only on transmit bytes
    a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_TX))
        else $error("tlast on a status transaction");

    // status carries no transmit byte
    a_status_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_STATUS)) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("status transaction with nonzero tx byte");

    // failed status and transmit bytes carry no telemetry
    a_no_telemetry: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tuser == KIND_TX) || (m_axis_tdata[9:8] != ST_OK)))
        |-> (m_axis_tdata[63:10] == '0))
        else $error("telemetry present where it must be zero");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("output changed while stalled");

endmodule

bind motor_drive_frame_link mdfl_chk u_mdfl_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
